/* hw/rtl/set_assoc_fifo_key_value_cache_assert.svh */
// Assertion macros used by the cache RTL sequencer, sakv_seq.
`ifndef SET_ASSOC_FIFO_KEY_VALUE_CACHE_ASSERT_SVH
`define SET_ASSOC_FIFO_KEY_VALUE_CACHE_ASSERT_SVH

`ifndef SYNTHESIS

// prop must hold at every rising clock edge outside reset
`define SAKV_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sakv assertion failed");

// cond must never be true outside reset
`define SAKV_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("sakv forbidden condition seen");

`else

`define SAKV_ASSERT(lbl, clk, rst, prop)
`define SAKV_ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

/* hw/rtl/sakv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sakv_pkg;

   localparam int SET_BITS   = 8;
   localparam int WAYS       = 4;
   localparam int KEY_BITS   = 64;
   localparam int VALUE_BITS = 64;

   localparam int SETS      = 2 ** SET_BITS;
   localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int FILL_BITS = $clog2(WAYS + 1);
   localparam int ADDR_BITS = SET_BITS + WAY_BITS;

   localparam int SET_IDX_W = 8;
   localparam int KEY_W     = 64;
   localparam int VALUE_W   = 64;

   localparam logic MODE_LOOKUP = 1'b0;
   localparam logic MODE_INSERT = 1'b1;

   typedef struct packed {
      logic                 mode;
      logic [SET_IDX_W-1:0] set_index;
      logic [KEY_W-1:0]     key;
      logic [VALUE_W-1:0]   value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [VALUE_W-1:0] value_out;
   } rsp_type;

   typedef struct packed {
      logic [FILL_BITS-1:0] fill;
      logic [WAY_BITS-1:0]  next;
   } meta_type;

   typedef struct packed {
      logic                en;
      logic [SET_BITS-1:0] set_sel;
      meta_type            meta;
   } meta_wr_type;

   typedef struct packed {
      logic                  en;
      logic [ADDR_BITS-1:0]  addr;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } way_wr_type;

   // low SET_BITS of the set index field, zero filled if SET_BITS is wider
   function automatic logic [SET_BITS-1:0] set_of(input logic [SET_IDX_W-1:0] idx);
      logic [SET_BITS+SET_IDX_W-1:0] ext;
      ext = {{SET_BITS{1'b0}}, idx};
      return ext[SET_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/sakv_set_meta.sv */
`timescale 1ns / 1ps
`default_nettype none

module sakv_set_meta (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [sakv_pkg::SET_BITS-1:0] rd_set,
   input  sakv_pkg::meta_wr_type        wr,
   output sakv_pkg::meta_type           rd_meta
);

   sakv_pkg::meta_type meta_mem [sakv_pkg::SETS];
   sakv_pkg::meta_type rd_data_ff;

   logic [sakv_pkg::SETS-1:0] valid_ff;
   logic [sakv_pkg::SETS-1:0] valid_in;
   logic                      rd_valid_ff;
   logic                      rd_valid_in;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         meta_mem[wr.set_sel] <= wr.meta;
      end
      rd_data_ff <= meta_mem[rd_set];
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.set_sel] = 1'b1;
      end
      rd_valid_in = valid_ff[rd_set];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   // a set never written reads as empty with the pointer at way 0
   assign rd_meta = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

/* hw/rtl/sakv_way_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module sakv_way_store (
   input  logic                            clock,
   input  logic [sakv_pkg::ADDR_BITS-1:0]  rd_addr,
   input  sakv_pkg::way_wr_type            wr,
   output logic [sakv_pkg::KEY_BITS-1:0]   rd_key,
   output logic [sakv_pkg::VALUE_BITS-1:0] rd_value
);

   localparam int DEPTH = 2 ** sakv_pkg::ADDR_BITS;

   logic [sakv_pkg::KEY_BITS-1:0]   key_mem   [DEPTH];
   logic [sakv_pkg::VALUE_BITS-1:0] value_mem [DEPTH];

   logic [sakv_pkg::KEY_BITS-1:0]   rd_key_ff;
   logic [sakv_pkg::VALUE_BITS-1:0] rd_value_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         key_mem[wr.addr]   <= wr.key;
         value_mem[wr.addr] <= wr.value;
      end
      rd_key_ff   <= key_mem[rd_addr];
      rd_value_ff <= value_mem[rd_addr];
   end

   assign rd_key   = rd_key_ff;
   assign rd_value = rd_value_ff;

endmodule

`default_nettype wire

/* hw/rtl/sakv_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module sakv_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  sakv_pkg::req_type               req,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output sakv_pkg::rsp_type               rsp,
   output logic [sakv_pkg::SET_BITS-1:0]   meta_rd_set,
   input  sakv_pkg::meta_type              rd_meta,
   output sakv_pkg::meta_wr_type           meta_wr,
   output logic [sakv_pkg::ADDR_BITS-1:0]  way_rd_addr,
   input  logic [sakv_pkg::KEY_BITS-1:0]   rd_key,
   input  logic [sakv_pkg::VALUE_BITS-1:0] rd_value,
   output sakv_pkg::way_wr_type            way_wr
);

`include "set_assoc_fifo_key_value_cache_assert.svh"

   localparam int FB = sakv_pkg::FILL_BITS;
   localparam int WB = sakv_pkg::WAY_BITS;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_META = 2'd1;
   localparam logic [1:0] ST_CMP  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]                      state_ff, state_in;
   logic                            mode_ff, mode_in;
   logic [sakv_pkg::SET_BITS-1:0]   set_ff, set_in;
   logic [sakv_pkg::KEY_BITS-1:0]   key_ff, key_in;
   logic [sakv_pkg::VALUE_BITS-1:0] val_ff, val_in;
   logic [FB-1:0]                   fill_ff, fill_in;
   logic [WB-1:0]                   next_ff, next_in;
   logic [FB-1:0]                   way_ff, way_in;
   logic                            hit_ff, hit_in;
   logic [sakv_pkg::VALUE_BITS-1:0] out_ff, out_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   sakv_pkg::rsp_type               rsp_ff, rsp_in;

   logic               req_accept;
   logic               key_match;
   logic               decide;
   logic               found;
   logic               out_free;
   logic [FB-1:0]      way_nx;
   sakv_pkg::meta_type cur_meta;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign meta_rd_set = sakv_pkg::set_of(req.set_index);
   assign key_match   = (rd_key == key_ff);
   assign way_nx      = way_ff + FB'(1);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign way_rd_addr = {set_ff, way_in[WB-1:0]};

   always_comb begin
      cur_meta.fill = fill_ff;
      cur_meta.next = next_ff;
      if (state_ff == ST_META) begin
         cur_meta = rd_meta;
      end
   end

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      set_in   = set_ff;
      key_in   = key_ff;
      val_in   = val_ff;
      fill_in  = fill_ff;
      next_in  = next_ff;
      way_in   = way_ff;
      hit_in   = hit_ff;
      out_in   = out_ff;
      decide   = 1'b0;
      found    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               mode_in  = req.mode;
               set_in   = sakv_pkg::set_of(req.set_index);
               key_in   = req.key[sakv_pkg::KEY_BITS-1:0];
               val_in   = req.value[sakv_pkg::VALUE_BITS-1:0];
               state_in = ST_META;
            end
         end
         ST_META: begin
            fill_in = rd_meta.fill;
            next_in = rd_meta.next;
            way_in  = '0;
            if (rd_meta.fill == '0) begin
               decide = 1'b1;
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            // one way per cycle through the shared comparator
            if (key_match) begin
               decide = 1'b1;
               found  = 1'b1;
            end else if (way_nx == fill_ff) begin
               decide = 1'b1;
            end else begin
               way_in = way_nx;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (decide) begin
         hit_in   = found;
         out_in   = (found && mode_ff == sakv_pkg::MODE_LOOKUP) ? rd_value : '0;
         state_in = out_free ? ST_IDLE : ST_DONE;
      end
   end

   // output register: loaded straight from the decision or later from hold
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (decide && out_free) begin
         rsp_valid_in     = 1'b1;
         rsp_in.hit       = found;
         rsp_in.value_out = sakv_pkg::VALUE_W'(out_in);
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in     = 1'b1;
         rsp_in.hit       = hit_ff;
         rsp_in.value_out = sakv_pkg::VALUE_W'(out_ff);
      end
   end

   // insert miss: fill the way under the FIFO pointer, bump pointer and count
   always_comb begin
      way_wr.en    = decide && !found && (mode_ff == sakv_pkg::MODE_INSERT);
      way_wr.addr  = {set_ff, cur_meta.next};
      way_wr.key   = key_ff;
      way_wr.value = val_ff;

      meta_wr.en      = way_wr.en;
      meta_wr.set_sel = set_ff;
      meta_wr.meta.next = (cur_meta.next == WB'(sakv_pkg::WAYS - 1)) ?
                          '0 : cur_meta.next + WB'(1);
      meta_wr.meta.fill = (cur_meta.fill == FB'(sakv_pkg::WAYS)) ?
                          cur_meta.fill : cur_meta.fill + FB'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      set_ff  <= set_in;
      key_ff  <= key_in;
      val_ff  <= val_in;
      fill_ff <= fill_in;
      next_ff <= next_in;
      way_ff  <= way_in;
      hit_ff  <= hit_in;
      out_ff  <= out_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `SAKV_ASSERT(a_cmp_in_fill, clock, reset, (state_ff == ST_CMP) |-> (way_ff < fill_ff))
   `SAKV_ASSERT(a_fill_sat, clock, reset, (state_ff == ST_CMP) |-> (fill_ff <= FB'(sakv_pkg::WAYS)))
   `SAKV_ASSERT(a_wr_insert, clock, reset, way_wr.en |-> (mode_ff == sakv_pkg::MODE_INSERT))
   `SAKV_ASSERT(a_busy_after, clock, reset, req_accept |=> (state_ff == ST_META))
   `SAKV_ASSERT_NEVER(a_value_no_hit, clock, reset, rsp_valid_ff && !rsp_ff.hit && (rsp_ff.value_out != '0))

endmodule

`default_nettype wire

/* hw/rtl/set_assoc_fifo_key_value_cache.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake             Beat
// req      in   req_valid/req_stall   mode, set_index, key, value
// rsp      out  rsp_valid/rsp_stall   hit, value_out
//
// An item goes from accept to the result register through one set
// metadata read, then one way a cycle through the single key comparator;
// the number of ways compared is 0 to WAYS. The next beat is taken only
// once the sequencer is back in idle, so items never overlap. The request
// side is stalled while an item is in flight. Reset clears all set fill
// counts and FIFO pointers at once; there is no clearing pass. A held
// result may sit in the output register while the next beat is accepted.
module set_assoc_fifo_key_value_cache (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sakv_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sakv_pkg::rsp_type rsp
);

   logic [sakv_pkg::SET_BITS-1:0]   meta_rd_set;
   sakv_pkg::meta_type              rd_meta;
   sakv_pkg::meta_wr_type           meta_wr;
   logic [sakv_pkg::ADDR_BITS-1:0]  way_rd_addr;
   logic [sakv_pkg::KEY_BITS-1:0]   rd_key;
   logic [sakv_pkg::VALUE_BITS-1:0] rd_value;
   sakv_pkg::way_wr_type            way_wr;

   sakv_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req         (req),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp         (rsp),
      .meta_rd_set (meta_rd_set),
      .rd_meta     (rd_meta),
      .meta_wr     (meta_wr),
      .way_rd_addr (way_rd_addr),
      .rd_key      (rd_key),
      .rd_value    (rd_value),
      .way_wr      (way_wr)
   );

   sakv_set_meta u_set_meta (
      .clock   (clock),
      .reset   (reset),
      .rd_set  (meta_rd_set),
      .wr      (meta_wr),
      .rd_meta (rd_meta)
   );

   sakv_way_store u_way_store (
      .clock    (clock),
      .rd_addr  (way_rd_addr),
      .wr       (way_wr),
      .rd_key   (rd_key),
      .rd_value (rd_value)
   );

endmodule

`default_nettype wire
